// ----- rtl/gbfp_pkg.sv -----
// Shared types, constants and helpers for the binary GPS frame parser.
package gbfp_pkg;

  localparam int unsigned FrameLen  = 37;
  localparam int unsigned StoreLen  = FrameLen - 1;
  localparam int unsigned SumFirst  = 2;
  localparam int unsigned SumLast   = 34;
  localparam int unsigned CkAPos    = 35;
  localparam int unsigned CkBPos    = 36;
  localparam int unsigned PosW      = 6;
  localparam logic [7:0]  Hdr0      = 8'hD0;
  localparam logic [7:0]  Hdr1      = 8'hDD;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_CKSUM = 2'd1,
    STATUS_HDR   = 2'd2
  } status_e;

  // Frame bytes 0..35; the newest byte sits at index 0.
  typedef logic [StoreLen-1:0][7:0] frame_bytes_t;

  // Check-time view handed from the assembler to the judge.
  typedef struct packed {
    logic       judge;      // byte 36 accepted this cycle, frame complete
    logic       at_end;     // next byte is frame byte 36
    logic [7:0] last_byte;  // the byte being accepted (checksum B)
    logic [7:0] sum_a;
    logic [7:0] sum_b;
  } chk_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] altitude;
    logic signed [31:0] ground_speed;
    logic signed [31:0] heading;
    logic [7:0]         satellites;
    logic [7:0]         fix_type;
    logic signed [31:0] date_code;
    logic signed [31:0] utc_time;
    logic [15:0]        hdop;
  } result_t;

  // Frame byte k of a complete 36-byte store.
  function automatic logic [7:0] byte_at(frame_bytes_t f, int unsigned k);
    return f[StoreLen-1-k];
  endfunction

  function automatic logic [31:0] le32(frame_bytes_t f, int unsigned k);
    return {byte_at(f, k + 3), byte_at(f, k + 2), byte_at(f, k + 1), byte_at(f, k)};
  endfunction

endpackage

// ----- rtl/gbfp_assembler.sv -----
// Byte counter, Fletcher sums and frame shift line.
module gbfp_assembler (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  restart_i,
  output gbfp_pkg::chk_t        chk_o,
  output gbfp_pkg::frame_bytes_t frame_o
);

  logic [gbfp_pkg::PosW-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]                sum_a_q, sum_a_d, sum_a_base, sum_a_new;
  logic [7:0]                sum_b_q, sum_b_d, sum_b_base, sum_b_new;
  gbfp_pkg::frame_bytes_t    shift_q;
  logic                      in_sum, at_ck_b;

  always_comb begin
    pos_eff    = restart_i ? '0 : pos_q;
    sum_a_base = restart_i ? '0 : sum_a_q;
    sum_b_base = restart_i ? '0 : sum_b_q;
    in_sum     = (pos_eff >= gbfp_pkg::PosW'(gbfp_pkg::SumFirst))
              && (pos_eff <= gbfp_pkg::PosW'(gbfp_pkg::SumLast));
    at_ck_b    = (pos_eff == gbfp_pkg::PosW'(gbfp_pkg::CkBPos));
    sum_a_new  = in_sum ? sum_a_base + rx_byte_i : sum_a_base;
    sum_b_new  = in_sum ? sum_b_base + sum_a_new : sum_b_base;
    if (at_ck_b) begin
      pos_d   = '0;
      sum_a_d = '0;
      sum_b_d = '0;
    end else begin
      pos_d   = pos_eff + 1'b1;
      sum_a_d = sum_a_new;
      sum_b_d = sum_b_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  // Shift in every stored byte; hold on the checksum-B byte.
  always_ff @(posedge clk_i) begin
    if (accept_i && !at_ck_b) begin
      shift_q <= {shift_q[gbfp_pkg::StoreLen-2:0], rx_byte_i};
    end
  end

  assign chk_o.judge     = accept_i && at_ck_b;
  assign chk_o.at_end    = (pos_q == gbfp_pkg::PosW'(gbfp_pkg::CkBPos));
  assign chk_o.last_byte = rx_byte_i;
  assign chk_o.sum_a     = sum_a_q;
  assign chk_o.sum_b     = sum_b_q;
  assign frame_o         = shift_q;

endmodule

// ----- rtl/gbfp_judge.sv -----
// Checksum and header test, field extraction and result register.
module gbfp_judge (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gbfp_pkg::chk_t         chk_i,
  input  gbfp_pkg::frame_bytes_t frame_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output gbfp_pkg::result_t      result_o
);

  gbfp_pkg::result_t res_d, res_q;
  logic              valid_q, valid_d;
  logic              ck_bad, hdr_bad;

  always_comb begin
    ck_bad  = (chk_i.sum_a != gbfp_pkg::byte_at(frame_i, gbfp_pkg::CkAPos))
           || (chk_i.sum_b != chk_i.last_byte);
    hdr_bad = (gbfp_pkg::byte_at(frame_i, 0) != gbfp_pkg::Hdr0)
           || (gbfp_pkg::byte_at(frame_i, 1) != gbfp_pkg::Hdr1);
    res_d = '0;
    if (ck_bad) begin
      res_d.status = gbfp_pkg::STATUS_CKSUM;
    end else if (hdr_bad) begin
      res_d.status = gbfp_pkg::STATUS_HDR;
    end else begin
      res_d.status       = gbfp_pkg::STATUS_OK;
      res_d.latitude     = gbfp_pkg::le32(frame_i, 3);
      res_d.longitude    = gbfp_pkg::le32(frame_i, 7);
      res_d.altitude     = gbfp_pkg::le32(frame_i, 11);
      res_d.ground_speed = gbfp_pkg::le32(frame_i, 15);
      res_d.heading      = gbfp_pkg::le32(frame_i, 19);
      res_d.satellites   = gbfp_pkg::byte_at(frame_i, 23);
      res_d.fix_type     = gbfp_pkg::byte_at(frame_i, 24);
      res_d.date_code    = gbfp_pkg::le32(frame_i, 25);
      res_d.utc_time     = gbfp_pkg::le32(frame_i, 29);
      res_d.hdop         = {gbfp_pkg::byte_at(frame_i, 34), gbfp_pkg::byte_at(frame_i, 33)};
    end
    // Load on a new result, drop once the receiver takes it.
    if (chk_i.judge) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk_i.judge) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

// ----- rtl/gps_binary_frame_parser.sv -----
// Top level of the binary GPS frame parser.
//
// Input channel: one serial byte per transaction on rx_byte_i, qualified by
// in_valid_i and taken when in_stall_o is low. restart_i set with a byte
// drops any partial frame and makes that byte frame byte 0.
// Output channel: one result per 37-byte frame, presented on out_valid_o
// and taken when out_stall_i is low. status_o is 0 for a good frame, 1 on
// a checksum mismatch (tested first), 2 on a wrong header; error results
// carry zero in every other field.
// The result appears in the cycle after frame byte 36 is accepted.
// Throughput: one byte per cycle while in_stall_o is low. in_stall_o
// rises only while a result is waiting, the receiver stalls it and the
// byte position has reached 36, whether or not the next byte carries
// restart; all other bytes keep flowing into the frame shift line
// meanwhile.
// Reset clears the byte position, both sums and the result valid flag;
// the frame bytes themselves are not reset since each frame rewrites them.
module gps_binary_frame_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] latitude_o,
  output logic signed [31:0] longitude_o,
  output logic signed [31:0] altitude_o,
  output logic signed [31:0] ground_speed_o,
  output logic signed [31:0] heading_o,
  output logic [7:0]         satellites_o,
  output logic [7:0]         fix_type_o,
  output logic signed [31:0] date_code_o,
  output logic signed [31:0] utc_time_o,
  output logic [15:0]        hdop_o
);

  gbfp_pkg::chk_t         chk;
  gbfp_pkg::frame_bytes_t frame;
  gbfp_pkg::result_t      result;
  logic                   accept;

  // Hold the input only when a frame-closing byte could find the result
  // register occupied and blocked.
  assign in_stall_o = out_valid_o && out_stall_i && chk.at_end;
  assign accept     = in_valid_i && !in_stall_o;

  gbfp_assembler u_asm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .restart_i (restart_i),
    .chk_o     (chk),
    .frame_o   (frame)
  );

  gbfp_judge u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chk_i       (chk),
    .frame_i     (frame),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign status_o       = result.status;
  assign latitude_o     = result.latitude;
  assign longitude_o    = result.longitude;
  assign altitude_o     = result.altitude;
  assign ground_speed_o = result.ground_speed;
  assign heading_o      = result.heading;
  assign satellites_o   = result.satellites;
  assign fix_type_o     = result.fix_type;
  assign date_code_o    = result.date_code;
  assign utc_time_o     = result.utc_time;
  assign hdop_o         = result.hdop;

  // A frame-closing transaction never lands on a blocked result register.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk.judge |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  // A closed frame shows a result on the next cycle.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk.judge |=> out_valid_o)
    else $error("no result after frame byte 36");

  // Error results carry zero fields.
  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != gbfp_pkg::STATUS_OK) |->
      (latitude_o == 0 && utc_time_o == 0 && hdop_o == 0 && satellites_o == 0))
    else $error("error result with nonzero fields");

  // Stall on the input only ever comes from a waiting result.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && chk.at_end))
    else $error("input stalled without a pending result");

endmodule

// ----- tb/gps_binary_frame_parser_tb.sv -----
// Self-checking testbench for the binary GPS frame parser: frame table, then random traffic.
module gps_binary_frame_parser_tb;

  // How the payload bytes of a generated frame are filled.
  typedef enum int {
    FILL_ZERO,
    FILL_ONES,
    FILL_SIGN,
    FILL_WALK,
    FILL_RAND,
    FILL_MIXED
  } fill_e;

  // Deliberate damage applied after the checksum bytes are computed.
  typedef enum int {
    FLAW_NONE,
    FLAW_CK_A,
    FLAW_CK_B,
    FLAW_HDR0,
    FLAW_HDR1,
    FLAW_BOTH
  } flaw_e;

  typedef logic [7:0] frame_t [gbfp_pkg::FrameLen];

  // One row of the directed table: one frame, possibly cut short.
  typedef struct {
    fill_e             fill;
    flaw_e             flaw;
    int unsigned       len;
    bit                restart_first;
    bit                typed;
    gbfp_pkg::result_t want;
  } frame_row_t;

  localparam int unsigned RandomBytes = 490;
  localparam int unsigned IdlePct     = 23;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned TailCycles  = 8;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [7:0]         rx_byte_i   = '0;
  logic               restart_i   = 1'b0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] latitude_o;
  logic signed [31:0] longitude_o;
  logic signed [31:0] altitude_o;
  logic signed [31:0] ground_speed_o;
  logic signed [31:0] heading_o;
  logic [7:0]         satellites_o;
  logic [7:0]         fix_type_o;
  logic signed [31:0] date_code_o;
  logic signed [31:0] utc_time_o;
  logic [15:0]        hdop_o;

  // Frame parser shadow state: position, running sums and stored bytes.
  logic [5:0]        frame_pos;
  logic [7:0]        sum_lo;
  logic [7:0]        sum_hi;
  logic [7:0]        frame_mem [gbfp_pkg::StoreLen];
  gbfp_pkg::result_t frame_results_q[$];
  frame_row_t        plan[$];
  int unsigned       mismatch_count = 0;
  bit                calm = 1'b0;

  gps_binary_frame_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .latitude_o     (latitude_o),
    .longitude_o    (longitude_o),
    .altitude_o     (altitude_o),
    .ground_speed_o (ground_speed_o),
    .heading_o      (heading_o),
    .satellites_o   (satellites_o),
    .fix_type_o     (fix_type_o),
    .date_code_o    (date_code_o),
    .utc_time_o     (utc_time_o),
    .hdop_o         (hdop_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver side: stall at random, except during the calm stretch.
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
  end

  function automatic logic [31:0] word_at(int unsigned k);
    return {frame_mem[k + 3], frame_mem[k + 2], frame_mem[k + 1], frame_mem[k]};
  endfunction

  // Advance the shadow parser by one accepted byte; flag a result on frame byte 36.
  function automatic void predict_byte(input logic [7:0] b, input logic rs,
                                       output bit made, output gbfp_pkg::result_t r);
    int unsigned p;
    made = 1'b0;
    r = '0;
    if (rs) begin
      frame_pos = '0;
      sum_lo = '0;
      sum_hi = '0;
    end
    p = frame_pos;
    if (p >= gbfp_pkg::FrameLen) p = 0;
    if (p >= gbfp_pkg::SumFirst && p <= gbfp_pkg::SumLast) begin
      sum_lo = sum_lo + b;
      sum_hi = sum_hi + sum_lo;
    end
    if (p < gbfp_pkg::CkBPos) begin
      frame_mem[p] = b;
      frame_pos = 6'(p + 1);
      return;
    end
    // Judge the frame: checksum first, then header; errors carry zero fields.
    made = 1'b1;
    if (sum_lo != frame_mem[gbfp_pkg::CkAPos] || sum_hi != b) begin
      r.status = gbfp_pkg::STATUS_CKSUM;
    end else if (frame_mem[0] != gbfp_pkg::Hdr0 || frame_mem[1] != gbfp_pkg::Hdr1) begin
      r.status = gbfp_pkg::STATUS_HDR;
    end else begin
      r.status       = gbfp_pkg::STATUS_OK;
      r.latitude     = word_at(3);
      r.longitude    = word_at(7);
      r.altitude     = word_at(11);
      r.ground_speed = word_at(15);
      r.heading      = word_at(19);
      r.satellites   = frame_mem[23];
      r.fix_type     = frame_mem[24];
      r.date_code    = word_at(25);
      r.utc_time     = word_at(29);
      r.hdop         = {frame_mem[34], frame_mem[33]};
    end
    frame_pos = '0;
    sum_lo = '0;
    sum_hi = '0;
  endfunction

  // Build a 37-byte frame with valid header and checksums, then damage it as asked.
  function automatic frame_t build_frame(fill_e fill, flaw_e flaw);
    frame_t      f;
    logic [7:0]  a;
    logic [7:0]  s;
    int unsigned k;
    for (int i = 0; i < gbfp_pkg::FrameLen; i++) begin
      case (fill)
        FILL_ZERO: f[i] = 8'h00;
        FILL_ONES: f[i] = 8'hFF;
        FILL_SIGN: f[i] = 8'h80;
        FILL_WALK: f[i] = 8'(i * 7 + 1);
        FILL_MIXED: begin
          k = $urandom_range(0, 3);
          f[i] = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom);
        end
        default: f[i] = 8'($urandom);
      endcase
    end
    f[0] = gbfp_pkg::Hdr0;
    f[1] = gbfp_pkg::Hdr1;
    a = '0;
    s = '0;
    for (int i = gbfp_pkg::SumFirst; i <= gbfp_pkg::SumLast; i++) begin
      a = a + f[i];
      s = s + a;
    end
    f[gbfp_pkg::CkAPos] = a;
    f[gbfp_pkg::CkBPos] = s;
    case (flaw)
      FLAW_CK_A: f[gbfp_pkg::CkAPos] ^= 8'($urandom_range(1, 255));
      FLAW_CK_B: f[gbfp_pkg::CkBPos] ^= 8'($urandom_range(1, 255));
      FLAW_HDR0: f[0] ^= 8'($urandom_range(1, 255));
      FLAW_HDR1: f[1] ^= 8'($urandom_range(1, 255));
      FLAW_BOTH: begin
        f[0] ^= 8'($urandom_range(1, 255));
        f[gbfp_pkg::CkBPos] ^= 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    return f;
  endfunction

  // Result whose fields all repeat one pattern, for frames filled with a constant.
  function automatic gbfp_pkg::result_t fixed_result(gbfp_pkg::status_e st,
                                                     logic [31:0] w, logic [7:0] b);
    gbfp_pkg::result_t r;
    r.status       = st;
    r.latitude     = w;
    r.longitude    = w;
    r.altitude     = w;
    r.ground_speed = w;
    r.heading      = w;
    r.satellites   = b;
    r.fix_type     = b;
    r.date_code    = w;
    r.utc_time     = w;
    r.hdop         = w[15:0];
    return r;
  endfunction

  function automatic void add_row(fill_e fill, flaw_e flaw, int unsigned len, bit rs,
                                  bit typed, gbfp_pkg::result_t want);
    frame_row_t row;
    row.fill          = fill;
    row.flaw          = flaw;
    row.len           = len;
    row.restart_first = rs;
    row.typed         = typed;
    row.want          = want;
    plan.push_back(row);
  endfunction

  // Present one byte at a falling edge, hold it until accepted, then predict.
  task automatic send_byte(input logic [7:0] b, input logic rs,
                           output bit made, output gbfp_pkg::result_t r);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    restart_i  <= rs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b, rs, made, r);
    @(negedge clk_i);
  endtask

  task automatic send_frame(frame_t f, int unsigned len, bit restart_first, bit typed,
                            gbfp_pkg::result_t want);
    bit                made;
    gbfp_pkg::result_t r;
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(f[i], restart_first && i == 0, made, r);
      if (made) frame_results_q.push_back(typed ? want : r);
    end
  endtask

  // Hold the sender until every expected result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (frame_results_q.size() != 0);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports)
        $display("%0t %s: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Compare every taken result, field by field, with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    gbfp_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t result with none expected, status %0d", $time, status_o);
      end else begin
        want = frame_results_q.pop_front();
        check_field("status", status_o, want.status);
        check_field("latitude", latitude_o, want.latitude);
        check_field("longitude", longitude_o, want.longitude);
        check_field("altitude", altitude_o, want.altitude);
        check_field("ground_speed", ground_speed_o, want.ground_speed);
        check_field("heading", heading_o, want.heading);
        check_field("satellites", satellites_o, want.satellites);
        check_field("fix_type", fix_type_o, want.fix_type);
        check_field("date_code", date_code_o, want.date_code);
        check_field("utc_time", utc_time_o, want.utc_time);
        check_field("hdop", hdop_o, want.hdop);
      end
    end
  end

  initial begin
    frame_t            f;
    bit                made;
    gbfp_pkg::result_t r;
    int unsigned       sent;
    int unsigned       n_frames;
    int unsigned       pick;
    int unsigned       len;
    bit                rs;
    frame_pos = '0;
    sum_lo    = '0;
    sum_hi    = '0;
    foreach (frame_mem[i]) frame_mem[i] = '0;

    // Directed table. Constant fills and error frames have their result typed in.
    add_row(FILL_ZERO, FLAW_NONE, gbfp_pkg::FrameLen, 0, 1,
            fixed_result(gbfp_pkg::STATUS_OK, '0, '0));
    add_row(FILL_ONES, FLAW_NONE, gbfp_pkg::FrameLen, 0, 1,
            fixed_result(gbfp_pkg::STATUS_OK, 32'hFFFF_FFFF, 8'hFF));
    add_row(FILL_SIGN, FLAW_NONE, gbfp_pkg::FrameLen, 0, 1,
            fixed_result(gbfp_pkg::STATUS_OK, 32'h8080_8080, 8'h80));
    add_row(FILL_RAND, FLAW_NONE, gbfp_pkg::FrameLen, 0, 0, '0);
    add_row(FILL_RAND, FLAW_CK_A, gbfp_pkg::FrameLen, 0, 1,
            fixed_result(gbfp_pkg::STATUS_CKSUM, '0, '0));
    add_row(FILL_RAND, FLAW_CK_B, gbfp_pkg::FrameLen, 0, 1,
            fixed_result(gbfp_pkg::STATUS_CKSUM, '0, '0));
    add_row(FILL_RAND, FLAW_HDR0, gbfp_pkg::FrameLen, 0, 1,
            fixed_result(gbfp_pkg::STATUS_HDR, '0, '0));
    add_row(FILL_RAND, FLAW_HDR1, gbfp_pkg::FrameLen, 0, 1,
            fixed_result(gbfp_pkg::STATUS_HDR, '0, '0));
    // Header and checksum both wrong: the checksum error wins.
    add_row(FILL_RAND, FLAW_BOTH, gbfp_pkg::FrameLen, 0, 1,
            fixed_result(gbfp_pkg::STATUS_CKSUM, '0, '0));
    add_row(FILL_ZERO, FLAW_HDR1, gbfp_pkg::FrameLen, 0, 1,
            fixed_result(gbfp_pkg::STATUS_HDR, '0, '0));
    add_row(FILL_ONES, FLAW_CK_B, gbfp_pkg::FrameLen, 0, 1,
            fixed_result(gbfp_pkg::STATUS_CKSUM, '0, '0));
    add_row(FILL_WALK, FLAW_NONE, gbfp_pkg::FrameLen, 0, 0, '0);
    // Stop one byte short, so the next restart lands on frame byte 36.
    add_row(FILL_RAND, FLAW_NONE, gbfp_pkg::CkBPos, 0, 0, '0);
    add_row(FILL_RAND, FLAW_NONE, gbfp_pkg::FrameLen, 1, 0, '0);
    // Drop a partial frame partway through.
    add_row(FILL_MIXED, FLAW_NONE, 20, 0, 0, '0);
    add_row(FILL_ONES, FLAW_NONE, gbfp_pkg::FrameLen, 1, 1,
            fixed_result(gbfp_pkg::STATUS_OK, 32'hFFFF_FFFF, 8'hFF));
    // Restart on a byte that is already frame byte 0.
    add_row(FILL_RAND, FLAW_NONE, gbfp_pkg::FrameLen, 1, 0, '0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      f = build_frame(plan[i].fill, plan[i].flaw);
      send_frame(f, plan[i].len, plan[i].restart_first, plan[i].typed, plan[i].want);
    end
    drain();

    // Random traffic: mostly well-formed frames, some damaged, cut short or pure noise.
    // Resynchronize with a restart whenever the stream is out of frame alignment.
    sent = 0;
    n_frames = 0;
    while (sent < RandomBytes) begin
      calm = (n_frames >= 4 && n_frames < 10);
      if (n_frames == 12) drain();
      pick = $urandom_range(0, 99);
      rs = (frame_pos != 0) || ($urandom_range(0, 7) == 0);
      if (pick < 93) begin
        len = gbfp_pkg::FrameLen;
        if (pick < 70) begin
          f = build_frame((pick < 10) ? FILL_MIXED : FILL_RAND, FLAW_NONE);
        end else if (pick < 85) begin
          f = build_frame(FILL_RAND, flaw_e'($urandom_range(FLAW_CK_A, FLAW_BOTH)));
        end else begin
          f = build_frame(FILL_RAND, FLAW_NONE);
          len = $urandom_range(1, gbfp_pkg::CkBPos);
        end
        send_frame(f, len, rs, 1'b0, '0);
      end else begin
        len = $urandom_range(1, 45);
        for (int unsigned i = 0; i < len; i++) begin
          send_byte(8'($urandom), $urandom_range(0, 15) == 0, made, r);
          if (made) frame_results_q.push_back(r);
        end
      end
      sent += len;
      n_frames++;
    end
    calm = 1'b0;
    drain();
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
